// ----- src/cau_pkg.sv -----
// Shared constants, types and helper functions of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int N_ITER    = 32;
	localparam int MW        = 64 + FRAC_BITS;
	localparam int ADDR_W    = 3;
	localparam logic REG_DIV_EPSILON = 1'b0;
	localparam logic [31:0] EPS_RESET = 32'd1;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_CONJ = 3'd3,
		OP_DIV  = 3'd4,
		OP_MAG  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} sat_t;

	typedef struct packed {
		logic        is_div;
		logic        is_mag;
		logic        dz;
		logic [31:0] pre_re;
		logic [31:0] pre_im;
		logic [1:0]  pre_st;
		logic [63:0] den;
		logic [63:0] rem_re;
		logic [63:0] rem_im;
		logic [31:0] low_re;
		logic [31:0] low_im;
		logic [31:0] q_re;
		logic [31:0] q_im;
		logic        neg_re;
		logic        neg_im;
		logic        ovf_re;
		logic        ovf_im;
		logic [33:0] srem;
		logic [63:0] slow;
		logic [31:0] root;
	} iter_t;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t r;
		r.sat = 1'b0;
		r.val = v[31:0];
		if (!((&v[65:31]) || !(|v[65:31]))) begin
			r.sat = 1'b1;
			r.val = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	function automatic logic signed [65:0] sext32(input logic [31:0] x);
		return {{34{x[31]}}, x};
	endfunction

endpackage
`default_nettype wire

// ----- src/cau_iter.sv -----
// One pipelined step of the restoring divider and square root.
`default_nettype none
module cau_iter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire cau_pkg::iter_t in_d,
	output logic                out_v,
	output cau_pkg::iter_t      out_d
);

	cau_pkg::iter_t nx;
	logic [64:0] r2_re;
	logic [64:0] r2_im;
	logic [33:0] trial;
	logic [35:0] sr2;
	logic        v_s1;
	cau_pkg::iter_t data_s1;

	always_comb begin
		nx = in_d;
		r2_re = {in_d.rem_re, in_d.low_re[31]};
		r2_im = {in_d.rem_im, in_d.low_im[31]};
		if (r2_re >= {1'b0, in_d.den}) begin
			nx.rem_re = 64'(r2_re - {1'b0, in_d.den});
			nx.q_re = {in_d.q_re[30:0], 1'b1};
		end else begin
			nx.rem_re = r2_re[63:0];
			nx.q_re = {in_d.q_re[30:0], 1'b0};
		end
		if (r2_im >= {1'b0, in_d.den}) begin
			nx.rem_im = 64'(r2_im - {1'b0, in_d.den});
			nx.q_im = {in_d.q_im[30:0], 1'b1};
		end else begin
			nx.rem_im = r2_im[63:0];
			nx.q_im = {in_d.q_im[30:0], 1'b0};
		end
		nx.low_re = {in_d.low_re[30:0], 1'b0};
		nx.low_im = {in_d.low_im[30:0], 1'b0};
		trial = {in_d.root, 2'b01};
		sr2 = {in_d.srem, in_d.slow[63:62]};
		if (sr2 >= {2'b00, trial}) begin
			nx.srem = 34'(sr2 - {2'b00, trial});
			nx.root = {in_d.root[30:0], 1'b1};
		end else begin
			nx.srem = sr2[33:0];
			nx.root = {in_d.root[30:0], 1'b0};
		end
		nx.slow = {in_d.slow[61:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nx;
		end
	end

	assign out_v = v_s1;
	assign out_d = data_s1;

endmodule
`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
// Top level of the pipelined complex-number arithmetic unit.
// Usage: items enter on the req channel (opcode and operands a, b in signed
// Q16.16) and results leave on the rsp channel (res_re, res_im, status).
// Both channels use a valid/ready handshake, and one result leaves per item
// in the order of entry.
// The accepting edge loads the first of four stages of multiply, sum and
// setup; then come 32 stages of the shared restoring divider and square root
// and the output register, which drives rsp_valid.
// One item can enter every cycle, so the sustained throughput is one item
// per cycle while the receiver keeps rsp_ready high.
// When the receiver stalls, the item that reaches the output goes into a
// skid register; req_ready then drops, the whole pipeline holds, and no item
// is lost or repeated.
// Reset clears all valid bits and sets div_epsilon to 1.
// div_epsilon is written through the APB port at addresses 0 to 3 (paddr[2]
// low); pready is tied high.
`default_nettype none
module complex_arithmetic_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cau_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire logic [2:0]                 opcode,
	input  wire logic signed [31:0]         a_re,
	input  wire logic signed [31:0]         a_im,
	input  wire logic signed [31:0]         b_re,
	input  wire logic signed [31:0]         b_im,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output logic signed [31:0]              res_re,
	output logic signed [31:0]              res_im,
	output logic [1:0]                      status
);

	typedef struct packed {
		logic               is_mul;
		logic               is_div;
		logic               is_mag;
		logic [31:0]        pre_re;
		logic [31:0]        pre_im;
		logic [1:0]         pre_st;
		logic signed [63:0] p0;
		logic signed [63:0] p1;
		logic signed [63:0] p2;
		logic signed [63:0] p3;
		logic signed [63:0] p4;
		logic signed [63:0] p5;
	} st1_t;

	typedef struct packed {
		logic               is_mul;
		logic               is_div;
		logic               is_mag;
		logic [31:0]        pre_re;
		logic [31:0]        pre_im;
		logic [1:0]         pre_st;
		logic signed [65:0] mre;
		logic signed [65:0] mim;
		logic signed [65:0] nr;
		logic signed [65:0] ni;
		logic [63:0]        den;
	} st2_t;

	typedef struct packed {
		logic        is_div;
		logic        is_mag;
		logic        dz;
		logic [31:0] pre_re;
		logic [31:0] pre_im;
		logic [1:0]  pre_st;
		logic [63:0] den;
		logic [63:0] abs_re;
		logic [63:0] abs_im;
		logic        neg_re;
		logic        neg_im;
		logic [63:0] sq;
	} st3_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} res_t;

	logic [31:0] eps_q;
	logic        en;
	logic        v_s1, v_s2, v_s3, v_s4;
	st1_t        n1, data_s1;
	st2_t        n2, data_s2;
	st3_t        n3, data_s3;
	cau_pkg::iter_t n4, data_s4;
	cau_pkg::iter_t it_d [0:cau_pkg::N_ITER];
	logic        it_v [0:cau_pkg::N_ITER];
	res_t        fin;
	res_t        out_q, skid_q;
	logic        out_v_q, skid_v_q;

	function automatic cau_pkg::sat_t div_lane(input logic [31:0] q, input logic neg,
			input logic ovf);
		cau_pkg::sat_t r;
		r.sat = 1'b0;
		r.val = q;
		if (neg) begin
			if (ovf || (q > 32'h8000_0000)) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'(~q + 32'd1);
			end
		end else if (ovf || q[31]) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= cau_pkg::EPS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == cau_pkg::REG_DIV_EPSILON)) begin
			eps_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == cau_pkg::REG_DIV_EPSILON) ? eps_q : 32'd0;

	assign en = !skid_v_q;
	assign req_ready = en;

	// Stage 1: products and the simple operations.
	always_comb begin
		cau_pkg::sat_t sr, si;
		logic signed [31:0] xr, xi;
		n1 = '0;
		sr = '0;
		si = '0;
		xr = b_re;
		xi = b_im;
		n1.pre_st = cau_pkg::ST_OK;
		case (opcode)
			cau_pkg::OP_ADD: begin
				sr = cau_pkg::sat32(cau_pkg::sext32(a_re) + cau_pkg::sext32(b_re));
				si = cau_pkg::sat32(cau_pkg::sext32(a_im) + cau_pkg::sext32(b_im));
			end
			cau_pkg::OP_SUB: begin
				sr = cau_pkg::sat32(cau_pkg::sext32(a_re) - cau_pkg::sext32(b_re));
				si = cau_pkg::sat32(cau_pkg::sext32(a_im) - cau_pkg::sext32(b_im));
			end
			cau_pkg::OP_CONJ: begin
				sr = cau_pkg::sat32(cau_pkg::sext32(a_re));
				si = cau_pkg::sat32(66'sd0 - cau_pkg::sext32(a_im));
			end
			cau_pkg::OP_MUL: n1.is_mul = 1'b1;
			cau_pkg::OP_DIV: n1.is_div = 1'b1;
			cau_pkg::OP_MAG: begin
				n1.is_mag = 1'b1;
				xr = a_re;
				xi = a_im;
			end
			default: ;
		endcase
		n1.pre_re = sr.val;
		n1.pre_im = si.val;
		if (sr.sat || si.sat) begin
			n1.pre_st = cau_pkg::ST_SAT;
		end
		n1.p0 = a_re * xr;
		n1.p1 = a_im * xi;
		n1.p2 = a_re * b_im;
		n1.p3 = a_im * b_re;
		n1.p4 = b_re * b_re;
		n1.p5 = b_im * b_im;
	end

	// Stage 2: sums of products.
	always_comb begin
		n2.is_mul = data_s1.is_mul;
		n2.is_div = data_s1.is_div;
		n2.is_mag = data_s1.is_mag;
		n2.pre_re = data_s1.pre_re;
		n2.pre_im = data_s1.pre_im;
		n2.pre_st = data_s1.pre_st;
		n2.mre = 66'(data_s1.p0) - 66'(data_s1.p1);
		n2.mim = 66'(data_s1.p2) + 66'(data_s1.p3);
		n2.nr  = 66'(data_s1.p0) + 66'(data_s1.p1);
		n2.ni  = 66'(data_s1.p3) - 66'(data_s1.p2);
		n2.den = 64'(data_s1.p4) + 64'(data_s1.p5);
	end

	// Stage 3: multiply result, zero or below-epsilon divisor test, numerator magnitudes.
	always_comb begin
		cau_pkg::sat_t sr, si;
		logic signed [65:0] ar, ai;
		n3.is_div = data_s2.is_div;
		n3.is_mag = data_s2.is_mag;
		n3.pre_re = data_s2.pre_re;
		n3.pre_im = data_s2.pre_im;
		n3.pre_st = data_s2.pre_st;
		sr = cau_pkg::sat32(data_s2.mre >>> cau_pkg::FRAC_BITS);
		si = cau_pkg::sat32(data_s2.mim >>> cau_pkg::FRAC_BITS);
		if (data_s2.is_mul) begin
			n3.pre_re = sr.val;
			n3.pre_im = si.val;
			n3.pre_st = (sr.sat || si.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
		n3.den = data_s2.den;
		n3.dz = (data_s2.den == 64'd0) || (data_s2.den < {32'd0, eps_q});
		ar = data_s2.nr[65] ? -data_s2.nr : data_s2.nr;
		ai = data_s2.ni[65] ? -data_s2.ni : data_s2.ni;
		n3.abs_re = ar[63:0];
		n3.abs_im = ai[63:0];
		n3.neg_re = data_s2.nr[65];
		n3.neg_im = data_s2.ni[65];
		n3.sq = data_s2.nr[63:0];
	end

	// Stage 4: divider and square root setup.
	always_comb begin
		logic [cau_pkg::MW-1:0] mr, mi;
		mr = {data_s3.abs_re, {cau_pkg::FRAC_BITS{1'b0}}};
		mi = {data_s3.abs_im, {cau_pkg::FRAC_BITS{1'b0}}};
		n4 = '0;
		n4.is_div = data_s3.is_div;
		n4.is_mag = data_s3.is_mag;
		n4.dz = data_s3.dz;
		n4.pre_re = data_s3.pre_re;
		n4.pre_im = data_s3.pre_im;
		n4.pre_st = data_s3.pre_st;
		n4.den = data_s3.den;
		n4.rem_re = 64'(mr[cau_pkg::MW-1:32]);
		n4.rem_im = 64'(mi[cau_pkg::MW-1:32]);
		n4.low_re = mr[31:0];
		n4.low_im = mi[31:0];
		n4.ovf_re = 64'(mr[cau_pkg::MW-1:32]) >= data_s3.den;
		n4.ovf_im = 64'(mi[cau_pkg::MW-1:32]) >= data_s3.den;
		n4.neg_re = data_s3.neg_re;
		n4.neg_im = data_s3.neg_im;
		n4.slow = data_s3.sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= n1;
			data_s2 <= n2;
			data_s3 <= n3;
			data_s4 <= n4;
		end
	end

	assign it_d[0] = data_s4;
	assign it_v[0] = v_s4;

	for (genvar k = 0; k < cau_pkg::N_ITER; k++) begin : g_iter
		cau_iter u_iter (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (it_v[k]),
			.in_d   (it_d[k]),
			.out_v  (it_v[k+1]),
			.out_d  (it_d[k+1])
		);
	end

	// Final selection, sign and saturation.
	always_comb begin
		cau_pkg::sat_t dr, di;
		cau_pkg::iter_t t;
		t = it_d[cau_pkg::N_ITER];
		dr = div_lane(t.q_re, t.neg_re, t.ovf_re);
		di = div_lane(t.q_im, t.neg_im, t.ovf_im);
		fin.re = t.pre_re;
		fin.im = t.pre_im;
		fin.st = t.pre_st;
		if (t.is_div) begin
			if (t.dz) begin
				fin.re = 32'd0;
				fin.im = 32'd0;
				fin.st = cau_pkg::ST_DZ;
			end else begin
				fin.re = dr.val;
				fin.im = di.val;
				fin.st = (dr.sat || di.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end else if (t.is_mag) begin
			fin.re = t.root[31] ? 32'h7FFF_FFFF : t.root;
			fin.im = 32'd0;
			fin.st = t.root[31] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || rsp_ready) begin
			out_v_q <= skid_v_q || it_v[cau_pkg::N_ITER];
			skid_v_q <= 1'b0;
		end else if (en && it_v[cau_pkg::N_ITER]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || rsp_ready) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (en && it_v[cau_pkg::N_ITER]) begin
			skid_q <= fin;
		end
	end

	assign rsp_valid = out_v_q;
	assign res_re = out_q.re;
	assign res_im = out_q.im;
	assign status = out_q.st;

endmodule
`default_nettype wire

// ----- src/cau_checker.sv -----
// Port-level checker of the complex arithmetic unit and its bind statement.
`default_nettype none
module cau_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic signed [31:0]         res_re,
	input wire logic signed [31:0]         res_im,
	input wire logic [1:0]                 status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_re) && $stable(res_im)
			&& $stable(status))
		else $error("Result changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 2'd3)
		else $error("Unknown status code.");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cau_pkg::ST_DZ |-> res_re == 32'd0 && res_im == 32'd0)
		else $error("Divide by zero with nonzero result.");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
		else $error("Input ready dropped without an output stall.");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
`default_nettype wire
